@@ rtl/csdp_pkg.sv @@
// shared types and constants for the clock synthesizer divider planner
// no dependencies; imported by every module of the block
`default_nettype none
package csdp_pkg;

    localparam int DIV_W     = 48;
    localparam int DIVISOR_W = 32;
    localparam int CNT_W     = 6;

    localparam logic [29:0] VCO_MIN_HZ    = 30'd600000000;
    localparam logic [32:0] VCO_MAX_HZ    = 33'd900000000;
    localparam logic [19:0] FRAC_DEN      = 20'd1000000;
    localparam logic [25:0] CRYSTAL_RESET = 26'd25000000;
    localparam logic [17:0] P1_OFFSET     = 18'd512;
    localparam logic [7:0]  CTRL_BASE     = 8'h40 | 8'h0C | 8'h03;
    localparam logic [7:0]  MASK_RESET    = 8'hFF;
    localparam logic [29:0] MIN_DIVIDER   = 30'd6;

    typedef struct packed {
        logic                 start;
        logic [CNT_W-1:0]     nbits;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/csdp_divider.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on csdp_pkg; dividend arrives left aligned to its top nbits
`default_nettype none
module csdp_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csdp_pkg::div_req_t req,
    output csdp_pkg::div_rsp_t     rsp
);
    import csdp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

@@ rtl/clock_synth_divider_planner.sv @@
// clock synthesizer divider planner: top level with sequencer and apb register
// depends on csdp_pkg and csdp_divider
//
// usage:
//   input channel (s_*): one beat per request. action 0 asks for freq_hz on
//   clock 0 or 1; action 1 enables or disables one output in the disable mask.
//   result channel (m_*): exactly one beat per input beat, in order.
//   apb port: one register, crystal_hz at address 0; write it only while idle, the block does not enforce it.
// sequence:
//   enable items and rejected set items: decode, then straight to finish.
//   set items: four passes through the shared bit-serial divider
//   (30 + 33 + 46 + 27 quotient bits) plus one to five multiply/compare
//   steps of the divider search.
// flow:
//   one item at a time; s_ready is high only while the sequencer is idle,
//   so a new item is taken only once the previous one has left the sequencer.
// reset:
//   crystal_hz returns to 25 MHz, all outputs disabled (mask 0xFF), no
//   result pending.
// stall:
//   a finished result waits in the output register until m_ready; a new
//   item may be accepted meanwhile and waits at its end until the slot frees
`default_nettype none
module clock_synth_divider_planner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [2:0]  s_clock_index,
    input  wire logic        s_enable_flag,
    input  wire logic [31:0] s_freq_hz,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_accepted,
    output logic [17:0]      m_pll_p1,
    output logic [19:0]      m_pll_p2,
    output logic [19:0]      m_pll_p3,
    output logic [17:0]      m_divider_p1,
    output logic [29:0]      m_output_divider,
    output logic [32:0]      m_vco_hz,
    output logic [7:0]       m_control_byte,
    output logic [7:0]       m_disable_mask
);
    import csdp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_DIV1_GO, ST_DIV1_WAIT, ST_MUL, ST_CHECK,
        ST_DIV2_GO, ST_DIV2_WAIT, ST_MUL3, ST_DIV3_GO, ST_DIV3_WAIT,
        ST_DIV4_GO, ST_DIV4_WAIT, ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration register
    logic [25:0] crystal_reg;
    logic [25:0] xtal;

    // latched request
    logic        action_reg;
    logic [2:0]  clk_reg;
    logic        en_reg;
    logic [31:0] freq_reg;

    // working values
    logic [29:0] div_reg;       // output divider under search
    logic        down_reg;      // still in the step-down phase
    logic [45:0] prod_reg;      // shared multiplier result
    logic [32:0] vco_reg;
    logic [10:0] a_reg;         // only low bits reach the 18-bit p1
    logic [25:0] rem_reg;
    logic [19:0] b_reg;
    logic [6:0]  t_reg;
    logic [7:0]  mask_reg;

    // result register
    logic        m_valid_reg;
    logic        acc_out_reg;
    logic [17:0] p1_out_reg;
    logic [19:0] p2_out_reg;
    logic [19:0] p3_out_reg;
    logic [17:0] mp1_out_reg;
    logic [29:0] d_out_reg;
    logic [32:0] vco_out_reg;
    logic [7:0]  ctrl_out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [31:0] mul_a;
    logic [29:0] mul_b;
    logic [61:0] mul_full;
    logic [29:0] q1;
    logic [29:0] d_start;
    logic        reject;
    logic        plan_ok;
    logic [7:0]  sel_bit;
    logic [17:0] p1_calc;
    logic [26:0] p2_wide;
    logic [17:0] mp1_calc;
    logic [7:0]  ctrl_calc;
    logic        out_free;

    assign xtal     = (crystal_reg == '0) ? 26'd1 : crystal_reg;
    assign pready   = 1'b1;
    assign prdata   = {6'b0, crystal_reg};
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    csdp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // divider operands per pass, dividends left aligned to 48 bits
    always_comb begin
        div_req = '0;
        unique case (state_reg)
            ST_DIV1_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = CNT_W'(30);
                div_req.dividend = {VCO_MIN_HZ, 18'b0};
                div_req.divisor  = freq_reg;
            end
            ST_DIV2_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = CNT_W'(33);
                div_req.dividend = {vco_reg, 15'b0};
                div_req.divisor  = {6'b0, xtal};
            end
            ST_DIV3_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = CNT_W'(46);
                div_req.dividend = {prod_reg, 2'b0};
                div_req.divisor  = {6'b0, xtal};
            end
            ST_DIV4_GO: begin
                div_req.start    = 1'b1;
                div_req.nbits    = CNT_W'(27);
                div_req.dividend = {b_reg, 7'b0, 21'b0};
                div_req.divisor  = {12'b0, FRAC_DEN};
            end
            default: div_req = '0;
        endcase
    end

    // one shared multiplier: freq * divider in the search, rem * 1e6 later
    always_comb begin
        if (state_reg == ST_MUL3) begin
            mul_a = {6'b0, rem_reg};
            mul_b = {10'b0, FRAC_DEN};
        end else begin
            mul_a = freq_reg;
            mul_b = div_reg;
        end
    end
    assign mul_full = mul_a * mul_b;

    // starting divider: at least 6, rounded up to even
    assign q1      = div_rsp.quotient[29:0];
    assign d_start = (q1 < MIN_DIVIDER) ? MIN_DIVIDER : (q1 + {29'b0, q1[0]});

    assign reject    = (clk_reg > 3'd1) || (freq_reg == '0);
    assign plan_ok   = !action_reg && !reject;
    assign sel_bit   = 8'd1 << clk_reg;
    assign p1_calc   = {a_reg, 7'b0} + {11'b0, t_reg} - P1_OFFSET;
    assign p2_wide   = {b_reg, 7'b0} - 27'(t_reg) * 27'(FRAC_DEN);
    assign mp1_calc  = {div_reg[10:0], 7'b0} - P1_OFFSET;
    assign ctrl_calc = CTRL_BASE | {2'b0, clk_reg[0], 5'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            crystal_reg <= CRYSTAL_RESET;
            mask_reg    <= MASK_RESET;
            m_valid_reg <= 1'b0;
            down_reg    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
                crystal_reg <= pwdata[25:0];
            end
            // new beat loads as the old one leaves
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_action;
                        clk_reg    <= s_clock_index;
                        en_reg     <= s_enable_flag;
                        freq_reg   <= s_freq_hz;
                        state_reg  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (action_reg || reject) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_DIV1_GO;
                    end
                end
                ST_DIV1_GO: state_reg <= ST_DIV1_WAIT;
                ST_DIV1_WAIT: begin
                    if (div_rsp.done) begin
                        div_reg   <= d_start;
                        down_reg  <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_full[45:0];
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    // step down while above range, then up while below
                    if (down_reg && (prod_reg > {13'b0, VCO_MAX_HZ})
                            && (div_reg >= 30'd2)) begin
                        div_reg   <= div_reg - 30'd2;
                        state_reg <= ST_MUL;
                    end else if (prod_reg < {16'b0, VCO_MIN_HZ}) begin
                        down_reg  <= 1'b0;
                        div_reg   <= div_reg + 30'd2;
                        state_reg <= ST_MUL;
                    end else begin
                        down_reg  <= 1'b0;
                        vco_reg   <= prod_reg[32:0];
                        state_reg <= ST_DIV2_GO;
                    end
                end
                ST_DIV2_GO: state_reg <= ST_DIV2_WAIT;
                ST_DIV2_WAIT: begin
                    if (div_rsp.done) begin
                        a_reg     <= div_rsp.quotient[10:0];
                        rem_reg   <= div_rsp.remainder[25:0];
                        state_reg <= ST_MUL3;
                    end
                end
                ST_MUL3: begin
                    prod_reg  <= mul_full[45:0];
                    state_reg <= ST_DIV3_GO;
                end
                ST_DIV3_GO: state_reg <= ST_DIV3_WAIT;
                ST_DIV3_WAIT: begin
                    if (div_rsp.done) begin
                        b_reg     <= div_rsp.quotient[19:0];
                        state_reg <= ST_DIV4_GO;
                    end
                end
                ST_DIV4_GO: state_reg <= ST_DIV4_WAIT;
                ST_DIV4_WAIT: begin
                    if (div_rsp.done) begin
                        t_reg     <= div_rsp.quotient[6:0];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg    <= ST_IDLE;
                        acc_out_reg  <= action_reg || !reject;
                        p1_out_reg   <= plan_ok ? p1_calc : '0;
                        p2_out_reg   <= plan_ok ? p2_wide[19:0] : '0;
                        p3_out_reg   <= plan_ok ? FRAC_DEN : '0;
                        mp1_out_reg  <= plan_ok ? mp1_calc : '0;
                        d_out_reg    <= plan_ok ? div_reg : '0;
                        vco_out_reg  <= plan_ok ? vco_reg : '0;
                        ctrl_out_reg <= plan_ok ? ctrl_calc : '0;
                        if (action_reg) begin
                            mask_reg <= en_reg ? (mask_reg & ~sel_bit)
                                               : (mask_reg | sel_bit);
                        end else if (!reject) begin
                            mask_reg <= mask_reg & ~sel_bit;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = acc_out_reg;
    assign m_pll_p1         = p1_out_reg;
    assign m_pll_p2         = p2_out_reg;
    assign m_pll_p3         = p3_out_reg;
    assign m_divider_p1     = mp1_out_reg;
    assign m_output_divider = d_out_reg;
    assign m_vco_hz         = vco_out_reg;
    assign m_control_byte   = ctrl_out_reg;
    assign m_disable_mask   = mask_reg;
endmodule
`default_nettype wire

@@ rtl/csdp_checker.sv @@
// port level checks for the clock synthesizer divider planner
// depends on csdp_pkg; bound to clock_synth_divider_planner below
`default_nettype none
module csdp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_accepted,
    input wire logic [17:0] m_pll_p1,
    input wire logic [19:0] m_pll_p3,
    input wire logic [29:0] m_output_divider,
    input wire logic [32:0] m_vco_hz,
    input wire logic [7:0]  m_control_byte,
    input wire logic [7:0]  m_disable_mask
);
    import csdp_pkg::*;

    // one item at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vco_hz)
            && $stable(m_disable_mask))
        else $error("stalled result changed");

    // rejected beats carry no plan
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_pll_p1 == '0 && m_output_divider == '0
            && m_vco_hz == '0 && m_control_byte == '0)
        else $error("rejected beat carries plan data");

    // a computed plan has the fixed denominator and an even divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_output_divider != '0 |-> m_pll_p3 == FRAC_DEN
            && !m_output_divider[0] && m_accepted)
        else $error("plan fields inconsistent");
endmodule

bind clock_synth_divider_planner csdp_checker u_csdp_checker (.*);
`default_nettype wire
